// ===== rtl/core/accp_pkg.sv =====
// ----------------------------------------------------------------------------
// accp_pkg
// Shared widths, constants and types for the accelerometer pitch pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package accp_pkg;

  localparam int IN_W            = 16;             // raw sample field width
  localparam int SQ_W            = 32;             // x*x + z*z
  localparam int FRAC_SH         = 16;             // radicand shift, gives Q8 root
  localparam int RAD_W           = SQ_W + FRAC_SH; // radicand width
  localparam int ROOT_W          = RAD_W / 2;      // Q8 horizontal magnitude
  localparam int REM_W           = ROOT_W + 2;     // root remainder
  localparam int Y_FRAC          = 8;              // y aligned to Q8
  localparam int CX_W            = ROOT_W + 3;     // CORDIC x/y with gain headroom
  localparam int ANG_W           = 19;             // Q16 radians, signed
  localparam int ANGLE_TABLE_LEN = 24;
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int RTD_W           = 22;
  localparam logic [RTD_W-1:0] RAD_TO_DEG_Q16 = 22'd3754937;
  localparam int PROD_W          = ANG_W + RTD_W;
  localparam int DEG_SHIFT       = 32;
  localparam int DEG_W           = 8;
  localparam int DEG_LIMIT       = 90;

  // data carried alongside the arithmetic for the special cases
  typedef struct packed {
    logic signed [IN_W-1:0] y;
    logic                   h_zero;  // x and z both zero
  } accp_side_t;

  // atan(2^-i) in radians, Q16
  function automatic logic signed [ANG_W-1:0] atan_q16(input int i);
    logic signed [ANG_W-1:0] a;
    case (i)
      0:  a = 19'sd51472;
      1:  a = 19'sd30385;
      2:  a = 19'sd16055;
      3:  a = 19'sd8150;
      4:  a = 19'sd4091;
      5:  a = 19'sd2047;
      6:  a = 19'sd1024;
      7:  a = 19'sd512;
      8:  a = 19'sd256;
      9:  a = 19'sd128;
      10: a = 19'sd64;
      11: a = 19'sd32;
      12: a = 19'sd16;
      13: a = 19'sd8;
      14: a = 19'sd4;
      15: a = 19'sd2;
      16: a = 19'sd1;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/accp_sqmag.sv =====
// ----------------------------------------------------------------------------
// accp_sqmag
// Two-stage squared horizontal magnitude: x*x and z*z, then their sum.
// ----------------------------------------------------------------------------
`default_nettype none

module accp_sqmag (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           en,
  input  wire logic                           in_valid,
  input  wire logic signed [accp_pkg::IN_W-1:0] accel_x,
  input  wire logic signed [accp_pkg::IN_W-1:0] accel_y,
  input  wire logic signed [accp_pkg::IN_W-1:0] accel_z,
  output logic                                sq_valid,
  output logic [accp_pkg::SQ_W-1:0]           sq_mag,
  output accp_pkg::accp_side_t                sq_side
);
  import accp_pkg::*;

  logic signed [2*IN_W-1:0] xx_full;
  logic signed [2*IN_W-1:0] zz_full;

  logic              v1_r;
  logic [SQ_W-2:0]   xx_r;
  logic [SQ_W-2:0]   zz_r;
  accp_side_t        side1_r;
  logic              v2_r;
  logic [SQ_W-1:0]   sq_r;
  accp_side_t        side2_r;

  assign xx_full = accel_x * accel_x;
  assign zz_full = accel_z * accel_z;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // squares are non-negative and below 2^31
      xx_r           <= xx_full[SQ_W-2:0];
      zz_r           <= zz_full[SQ_W-2:0];
      side1_r.y      <= accel_y;
      side1_r.h_zero <= (accel_x == '0) && (accel_z == '0);
      sq_r           <= {1'b0, xx_r} + {1'b0, zz_r};
      side2_r        <= side1_r;
    end
  end

  assign sq_valid = v2_r;
  assign sq_mag   = sq_r;
  assign sq_side  = side2_r;

endmodule

`default_nettype wire

// ===== rtl/core/accp_isqrt.sv =====
// ----------------------------------------------------------------------------
// accp_isqrt
// Pipelined digit-by-digit integer square root, one result bit per stage.
// Root of (sq << 16), i.e. the magnitude in Q8.
// ----------------------------------------------------------------------------
`default_nettype none

module accp_isqrt (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    en,
  input  wire logic                    sq_valid,
  input  wire logic [accp_pkg::SQ_W-1:0] sq_mag,
  input  wire accp_pkg::accp_side_t    sq_side,
  output logic                         rt_valid,
  output logic [accp_pkg::ROOT_W-1:0]  rt_root,
  output accp_pkg::accp_side_t         rt_side
);
  import accp_pkg::*;

  logic              v_r    [ROOT_W];
  logic [RAD_W-1:0]  rad_r  [ROOT_W];
  logic [REM_W-1:0]  rem_r  [ROOT_W];
  logic [ROOT_W-1:0] root_r [ROOT_W];
  accp_side_t        side_r [ROOT_W];

  for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
    logic              v_in;
    logic [RAD_W-1:0]  rad_in;
    logic [REM_W-1:0]  rem_in;
    logic [ROOT_W-1:0] root_in;
    accp_side_t        side_in;
    logic [REM_W+1:0]  trial;
    logic [REM_W+1:0]  test;
    logic [REM_W+1:0]  diff;
    logic              ge;

    if (k == 0) begin : g_first
      assign v_in    = sq_valid;
      assign rad_in  = {sq_mag, {FRAC_SH{1'b0}}};
      assign rem_in  = '0;
      assign root_in = '0;
      assign side_in = sq_side;
    end else begin : g_next
      assign v_in    = v_r[k-1];
      assign rad_in  = rad_r[k-1];
      assign rem_in  = rem_r[k-1];
      assign root_in = root_r[k-1];
      assign side_in = side_r[k-1];
    end

    always_comb begin
      trial = {rem_in, rad_in[RAD_W-1 -: 2]};
      test  = {{(REM_W-ROOT_W){1'b0}}, root_in, 2'b01};
      diff  = trial - test;
      ge    = (trial >= test);
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rad_r[k]  <= rad_in << 2;
        // remainder stays at most twice the root
        rem_r[k]  <= ge ? diff[REM_W-1:0] : trial[REM_W-1:0];
        root_r[k] <= {root_in[ROOT_W-2:0], ge};
        side_r[k] <= side_in;
      end
    end
  end

  assign rt_valid = v_r[ROOT_W-1];
  assign rt_root  = root_r[ROOT_W-1];
  assign rt_side  = side_r[ROOT_W-1];

endmodule

`default_nettype wire

// ===== rtl/core/accp_cordic.sv =====
// ----------------------------------------------------------------------------
// accp_cordic
// Unrolled CORDIC vectoring on (magnitude, y), one iteration per stage.
// Accumulates the angle in Q16 radians.
// ----------------------------------------------------------------------------
`default_nettype none

module accp_cordic #(
  parameter int STEPS = accp_pkg::CORDIC_STEPS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          en,
  input  wire logic                          rt_valid,
  input  wire logic [accp_pkg::ROOT_W-1:0]   rt_root,
  input  wire accp_pkg::accp_side_t          rt_side,
  output logic                               an_valid,
  output logic signed [accp_pkg::ANG_W-1:0]  an_angle,
  output accp_pkg::accp_side_t               an_side
);
  import accp_pkg::*;

  localparam int NSTEPS = (STEPS > ANGLE_TABLE_LEN) ? ANGLE_TABLE_LEN :
                          ((STEPS < 1) ? 1 : STEPS);

  logic                    v_r    [NSTEPS];
  logic signed [CX_W-1:0]  cx_r   [NSTEPS];
  logic signed [CX_W-1:0]  cy_r   [NSTEPS];
  logic signed [ANG_W-1:0] ang_r  [NSTEPS];
  accp_side_t              side_r [NSTEPS];

  for (genvar k = 0; k < NSTEPS; k++) begin : g_iter
    logic                    v_in;
    logic signed [CX_W-1:0]  cx_in;
    logic signed [CX_W-1:0]  cy_in;
    logic signed [ANG_W-1:0] ang_in;
    accp_side_t              side_in;
    logic signed [CX_W-1:0]  dx;
    logic signed [CX_W-1:0]  dy;
    logic                    pos;

    if (k == 0) begin : g_first
      assign v_in    = rt_valid;
      assign cx_in   = {{(CX_W-ROOT_W){1'b0}}, rt_root};
      assign cy_in   = {{(CX_W-IN_W-Y_FRAC){rt_side.y[IN_W-1]}}, rt_side.y, {Y_FRAC{1'b0}}};
      assign ang_in  = '0;
      assign side_in = rt_side;
    end else begin : g_next
      assign v_in    = v_r[k-1];
      assign cx_in   = cx_r[k-1];
      assign cy_in   = cy_r[k-1];
      assign ang_in  = ang_r[k-1];
      assign side_in = side_r[k-1];
    end

    always_comb begin
      dx  = cy_in >>> k;
      dy  = cx_in >>> k;
      // rotate down only while y is strictly positive
      pos = !cy_in[CX_W-1] && (cy_in != '0);
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (pos) begin
          cx_r[k]  <= cx_in + dx;
          cy_r[k]  <= cy_in - dy;
          ang_r[k] <= ang_in + atan_q16(k);
        end else begin
          cx_r[k]  <= cx_in - dx;
          cy_r[k]  <= cy_in + dy;
          ang_r[k] <= ang_in - atan_q16(k);
        end
        side_r[k] <= side_in;
      end
    end
  end

  assign an_valid = v_r[NSTEPS-1];
  assign an_angle = ang_r[NSTEPS-1];
  assign an_side  = side_r[NSTEPS-1];

endmodule

`default_nettype wire

// ===== rtl/core/accp_scale.sv =====
// ----------------------------------------------------------------------------
// accp_scale
// Radians to whole degrees: |angle| times 180/pi in Q16, truncate, clamp,
// restore sign, and resolve the zero-y and vertical cases. Output register.
// ----------------------------------------------------------------------------
`default_nettype none

module accp_scale (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             en,
  input  wire logic                             an_valid,
  input  wire logic signed [accp_pkg::ANG_W-1:0] an_angle,
  input  wire accp_pkg::accp_side_t             an_side,
  output logic                                  out_valid,
  output logic signed [accp_pkg::DEG_W-1:0]     out_deg
);
  import accp_pkg::*;

  localparam int DEGF_W = PROD_W - DEG_SHIFT;

  logic [ANG_W-1:0]        ang_abs;
  logic [PROD_W-1:0]       prod;
  logic [DEGF_W-1:0]       deg_full;
  logic [DEG_W-1:0]        deg_mag;
  logic signed [DEG_W-1:0] deg_nxt;

  logic                    v1_r;
  logic [PROD_W-1:0]       prod_r;
  logic                    neg_r;
  accp_side_t              side1_r;
  logic                    v2_r;
  logic signed [DEG_W-1:0] deg_r;

  always_comb begin
    ang_abs = an_angle[ANG_W-1] ? ANG_W'(-an_angle) : an_angle;
    prod    = PROD_W'(ang_abs) * PROD_W'(RAD_TO_DEG_Q16);
  end

  always_comb begin
    deg_full = prod_r[PROD_W-1:DEG_SHIFT];
    if (deg_full > DEGF_W'(DEG_LIMIT)) begin
      deg_mag = DEG_W'(DEG_LIMIT);
    end else begin
      deg_mag = deg_full[DEG_W-1:0];
    end
    if (side1_r.y == '0) begin
      deg_nxt = '0;
    end else if (side1_r.h_zero) begin
      deg_nxt = side1_r.y[IN_W-1] ? -DEG_W'(DEG_LIMIT) : DEG_W'(DEG_LIMIT);
    end else begin
      deg_nxt = neg_r ? -deg_mag : deg_mag;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v1_r <= an_valid;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r  <= prod;
      neg_r   <= an_angle[ANG_W-1];
      side1_r <= an_side;
      deg_r   <= deg_nxt;
    end
  end

  assign out_valid = v2_r;
  assign out_deg   = deg_r;

endmodule

`default_nettype wire

// ===== rtl/core/accel_pitch_angle_top.sv =====
// Pitch angle of a three-axis accelerometer sample, atan2(y, sqrt(x*x+z*z)),
// in whole degrees truncated toward zero (-90..90). The pipeline takes one
// sample per cycle while not stalled, and each result passes through two
// stages for the squares, one stage per root bit of the 24-bit Q8
// magnitude, one stage per CORDIC iteration, and two for the degree
// scaling. The whole pipeline advances together; a stall on the output
// with a result waiting freezes every stage and raises in_stall. No state
// is kept between samples.
// ----------------------------------------------------------------------------
// accel_pitch_angle_top
// Top level: squared magnitude, square root, CORDIC vectoring, degree scale.
// ----------------------------------------------------------------------------
`default_nettype none

module accel_pitch_angle_top #(
  parameter int CORDIC_STEPS = accp_pkg::CORDIC_STEPS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic signed [accp_pkg::IN_W-1:0] in_accel_x,
  input  wire logic signed [accp_pkg::IN_W-1:0] in_accel_y,
  input  wire logic signed [accp_pkg::IN_W-1:0] in_accel_z,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic signed [accp_pkg::DEG_W-1:0]     out_pitch_degrees
);
  import accp_pkg::*;

  logic                    en;
  logic                    sq_valid;
  logic [SQ_W-1:0]         sq_mag;
  accp_side_t              sq_side;
  logic                    rt_valid;
  logic [ROOT_W-1:0]       rt_root;
  accp_side_t              rt_side;
  logic                    an_valid;
  logic signed [ANG_W-1:0] an_angle;
  accp_side_t              an_side;

  // advance unless a finished result is held by the consumer
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  accp_sqmag u_sqmag (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_valid),
    .accel_x  (in_accel_x),
    .accel_y  (in_accel_y),
    .accel_z  (in_accel_z),
    .sq_valid (sq_valid),
    .sq_mag   (sq_mag),
    .sq_side  (sq_side)
  );

  accp_isqrt u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .sq_valid (sq_valid),
    .sq_mag   (sq_mag),
    .sq_side  (sq_side),
    .rt_valid (rt_valid),
    .rt_root  (rt_root),
    .rt_side  (rt_side)
  );

  accp_cordic #(
    .STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .rt_valid (rt_valid),
    .rt_root  (rt_root),
    .rt_side  (rt_side),
    .an_valid (an_valid),
    .an_angle (an_angle),
    .an_side  (an_side)
  );

  accp_scale u_scale (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .an_valid  (an_valid),
    .an_angle  (an_angle),
    .an_side   (an_side),
    .out_valid (out_valid),
    .out_deg   (out_pitch_degrees)
  );

  a_deg_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_pitch_degrees <= 8'sd90) && (out_pitch_degrees >= -8'sd90))
    else $error("pitch result outside -90..90");

  a_reset_empties: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid straight after reset");

  a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_pitch_degrees))
    else $error("stalled result changed");

endmodule

`default_nettype wire

// ===== dv/accel_pitch_angle_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// accel_pitch_angle_top_tb
// Self-checking bench for the accelerometer pitch pipeline. Samples are
// driven at full rate with random idling and output stalls, and one long
// output hold-off. Each result is compared against a bit-exact integer
// square root and CORDIC prediction of the pitch in whole degrees.
// ----------------------------------------------------------------------------

module accel_pitch_angle_top_tb;

  localparam int  STEPS       = accp_pkg::CORDIC_STEPS_DEF;
  localparam int  RAND_ITEMS  = 1000;
  localparam int  HOLD_CYCLES = 250;
  localparam int  DRAIN       = 2 + 24 + STEPS + 2 + 60;
  localparam int  LIMIT       = 200000;

  // atan(2^-i) in radians, Q16
  localparam longint ATAN_Q16 [0:23] = '{
    51472, 30385, 16055, 8150, 4091, 2047, 1024, 512,
    256, 128, 64, 32, 16, 8, 4, 2,
    1, 0, 0, 0, 0, 0, 0, 0
  };

  typedef struct {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    logic signed [7:0]  pitch;
  } pitch_entry_t;

  class pitch_scoreboard;
    pitch_entry_t pending_pitch[$];
    int           errors = 0;

    function automatic logic signed [7:0] predict_pitch(logic signed [15:0] x, y, z);
      longint          hx, hy, ang, step_x, step_y, deg, sq;
      longint unsigned rem, root, probe, prod;
      int              steps;
      sq = longint'(x) * longint'(x) + longint'(z) * longint'(z);
      rem = $unsigned(sq) << 16;
      root = 0;
      probe = 64'd1 << 62;
      while (probe > rem) probe >>= 2;
      while (probe != 0) begin
        if (rem >= root + probe) begin
          rem -= root + probe;
          root = (root >> 1) + probe;
        end else begin
          root >>= 1;
        end
        probe >>= 2;
      end
      if (y == 0) return 8'sd0;
      if (root == 0) return (y > 0) ? 8'sd90 : -8'sd90;
      // Q8 vector (magnitude, y), vectored onto the x axis
      hx = longint'(root);
      hy = longint'(y) * 256;
      ang = 0;
      steps = (STEPS > 24) ? 24 : (STEPS < 1) ? 1 : STEPS;
      for (int i = 0; i < steps; i++) begin
        step_x = hy >>> i;
        step_y = hx >>> i;
        if (hy > 0) begin
          hx += step_x;
          hy -= step_y;
          ang += ATAN_Q16[i];
        end else begin
          hx -= step_x;
          hy += step_y;
          ang -= ATAN_Q16[i];
        end
      end
      prod = $unsigned((ang < 0) ? -ang : ang) * longint'(accp_pkg::RAD_TO_DEG_Q16);
      deg = longint'(prod >> 32);
      if (deg > accp_pkg::DEG_LIMIT) deg = accp_pkg::DEG_LIMIT;
      return 8'((ang < 0) ? -deg : deg);
    endfunction

    function void note_sample(logic signed [15:0] x, y, z);
      pitch_entry_t e;
      e.x = x;
      e.y = y;
      e.z = z;
      e.pitch = predict_pitch(x, y, z);
      pending_pitch.push_back(e);
    endfunction

    function void check_result(logic signed [7:0] got);
      pitch_entry_t e;
      if (pending_pitch.size() == 0) begin
        $error("pitch_degrees: no result pending, actual %0d", got);
        errors++;
        return;
      end
      e = pending_pitch.pop_front();
      if (got !== e.pitch) begin
        $error("pitch_degrees (x=%0d y=%0d z=%0d): expected %0d, actual %0d",
               e.x, e.y, e.z, e.pitch, got);
        errors++;
      end
    endfunction
  endclass

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  logic signed [15:0]  in_accel_x;
  logic signed [15:0]  in_accel_y;
  logic signed [15:0]  in_accel_z;
  logic                out_valid;
  logic                out_stall;
  logic signed [7:0]   out_pitch_degrees;

  pitch_scoreboard sb;
  int              sent;
  int              results;
  int              cycles;

  accel_pitch_angle_top #(
    .CORDIC_STEPS(STEPS)
  ) DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_accel_x       (in_accel_x),
    .in_accel_y       (in_accel_y),
    .in_accel_z       (in_accel_z),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_pitch_degrees(out_pitch_degrees)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // watchdog
  initial begin
    cycles = 0;
    while (cycles < LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  // one sample transfer, with an optional random idle gap beforehand
  task automatic send_sample(input logic signed [15:0] x, y, z, input bit may_idle);
    while (may_idle && $urandom_range(99) < 15) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_accel_x <= x;
    in_accel_y <= y;
    in_accel_z <= z;
    do @(posedge clk); while (in_stall);
    sb.note_sample(x, y, z);
    sent++;
  endtask

  function automatic logic signed [15:0] pick_edge();
    case ($urandom_range(5))
      0:       return -16'sd32768;
      1:       return -16'sd32767;
      2:       return -16'sd1;
      3:       return 16'sd0;
      4:       return 16'sd1;
      default: return 16'sd32767;
    endcase
  endfunction

  // result side: random stalls, a quiet stretch and one long hold-off
  initial begin
    int  hold_left;
    bit  hold_done;
    bit  calm;
    hold_left = 0;
    hold_done = 1'b0;
    results   = 0;
    out_stall <= 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) begin
        sb.check_result(out_pitch_degrees);
        results++;
      end
      if (results == 30 && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      calm = (results >= 350 && results < 600);
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !calm && ($urandom_range(99) < 15);
      end
    end
  end

  initial begin
    logic signed [15:0] x, y, z;
    bit                 may_idle;
    sb = new();
    sent = 0;
    rst_n      <= 1'b0;
    in_valid   <= 1'b0;
    in_accel_x <= '0;
    in_accel_y <= '0;
    in_accel_z <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: all zero, zero y, vertical, extremes, known angles
    send_sample(16'sd0, 16'sd0, 16'sd0, 1'b0);
    send_sample(16'sd1234, 16'sd0, -16'sd321, 1'b0);
    send_sample(-16'sd32768, 16'sd0, -16'sd32768, 1'b0);
    send_sample(16'sd0, 16'sd1, 16'sd0, 1'b0);
    send_sample(16'sd0, -16'sd1, 16'sd0, 1'b0);
    send_sample(16'sd0, 16'sd32767, 16'sd0, 1'b0);
    send_sample(16'sd0, -16'sd32768, 16'sd0, 1'b0);
    send_sample(-16'sd32768, -16'sd32768, -16'sd32768, 1'b0);
    send_sample(16'sd32767, 16'sd32767, 16'sd32767, 1'b0);
    send_sample(-16'sd32768, 16'sd32767, 16'sd0, 1'b0);
    send_sample(16'sd32767, -16'sd32768, -16'sd32768, 1'b0);
    send_sample(-16'sd32768, 16'sd1, -16'sd32768, 1'b0);
    send_sample(16'sd32767, -16'sd1, 16'sd32767, 1'b0);
    send_sample(16'sd0, 16'sd32767, 16'sd1, 1'b0);
    send_sample(16'sd1, -16'sd32768, 16'sd0, 1'b0);
    send_sample(16'sd0, 16'sd1000, 16'sd1000, 1'b0);
    send_sample(16'sd1000, -16'sd1000, 16'sd0, 1'b0);
    send_sample(16'sd0, 16'sd10000, 16'sd17321, 1'b0);
    send_sample(16'sd17321, -16'sd10000, 16'sd0, 1'b0);
    send_sample(16'sd0, 16'sd17321, 16'sd10000, 1'b0);
    send_sample(16'sd0, 16'sd16384, 16'sd0, 1'b0);
    send_sample(16'sd0, 16'sd0, 16'sd16384, 1'b0);
    send_sample(-16'sd3, 16'sd2, 16'sd4, 1'b0);

    for (int n = 0; n < RAND_ITEMS; n++) begin
      x = 16'($urandom);
      y = 16'($urandom);
      z = 16'($urandom);
      case ($urandom_range(9))
        4, 5: begin
          // realistic tilt around 1 g
          x = 16'(int'($urandom_range(40000)) - 20000);
          y = 16'(int'($urandom_range(40000)) - 20000);
          z = 16'(int'($urandom_range(40000)) - 20000);
        end
        6: begin
          x = 16'(int'($urandom_range(16)) - 8);
          y = 16'(int'($urandom_range(16)) - 8);
          z = 16'(int'($urandom_range(16)) - 8);
        end
        7: begin
          case ($urandom_range(2))
            0:       x = pick_edge();
            1:       y = pick_edge();
            default: z = pick_edge();
          endcase
        end
        8: y = '0;
        9: begin
          x = 16'(int'($urandom_range(4)) - 2);
          z = 16'(int'($urandom_range(4)) - 2);
        end
        default: ;
      endcase
      // a stretch of back-to-back transfers
      may_idle = !(n >= 300 && n < 550);
      send_sample(x, y, z, may_idle);
    end
    in_valid <= 1'b0;

    while (sb.pending_pitch.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);

    if (sb.errors == 0 && sb.pending_pitch.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
